// ----- rtl/run_length_line_detector_macros.svh -----
`ifndef RUN_LENGTH_LINE_DETECTOR_MACROS_SVH
`define RUN_LENGTH_LINE_DETECTOR_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define RLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define RLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rld_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W     = 8;
  localparam int SIZE_W    = 11;
  localparam int LEVEL_W   = 8;
  localparam int SEG_NUM_W = 16;
  localparam int COORD_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Column store entries carry a frame tag; the store is swept when the tag wraps.
  localparam int EPOCH_W = 8;

  localparam logic [SIZE_W-1:0]    RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [SIZE_W-1:0]    RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [SIZE_W-1:0]    RST_MIN_RUN      = 11'd341;
  localparam logic [LEVEL_W-1:0]   RST_DARK_LEVEL   = 8'd100;
  localparam logic [SEG_NUM_W-1:0] RST_MAX_SEGMENTS = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_MIN_RUN      = 3'd2,
    CFG_DARK_LEVEL   = 3'd3,
    CFG_MAX_SEGMENTS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0]   x_start;
    logic [COORD_W-1:0]   y_start;
    logic [COORD_W-1:0]   x_end;
    logic [COORD_W-1:0]   y_end;
    logic                 vertical;
    logic [SEG_NUM_W-1:0] number;
    logic                 last;
  } seg_t;

endpackage

`default_nettype wire

// ----- rtl/run_length_line_detector.sv -----
// Run-length line detector.
// Input channel: one RGB pixel per item (in_red, in_green, in_blue) in raster
// order; the block counts columns and rows itself against image_width and
// image_height. Output channel: one item per reported segment, row segment
// before column segment when a pixel closes both; out_last_of_pixel marks the
// final segment caused by a pixel. Both channels move an item on a rising
// edge with valid high and stall low.
// Throughput: one pixel per cycle while no more than one segment is waiting;
// a pixel that yields two segments needs both slots of the two-entry output
// buffer, so the input stalls until the buffer has room.
// An accepted pixel is held in the pixel register, which also holds the
// registered read of the column store; its segments are computed from there
// and written into the output buffer, from which they are offered.
// Reset: configuration returns to defaults and a clearing pass writes all
// MAX_WIDTH column entries, one per cycle while the pixel register is empty,
// with in_stall high; the pass reruns after every 256th frame as the tag wraps.
// When out_stall is held, the buffer fills and then in_stall rises; nothing
// is dropped. Configuration is written through cfg_we / cfg_index / cfg_wdata;
// the user must write it only while the block is idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module run_length_line_detector #(
  parameter int MAX_WIDTH  = rld_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rld_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rld_pkg::PIX_W-1:0]      in_red,
  input  wire logic [rld_pkg::PIX_W-1:0]      in_green,
  input  wire logic [rld_pkg::PIX_W-1:0]      in_blue,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rld_pkg::COORD_W-1:0]         out_seg_x_start,
  output logic [rld_pkg::COORD_W-1:0]         out_seg_y_start,
  output logic [rld_pkg::COORD_W-1:0]         out_seg_x_end,
  output logic [rld_pkg::COORD_W-1:0]         out_seg_y_end,
  output logic                                out_is_vertical,
  output logic [rld_pkg::SEG_NUM_W-1:0]       out_segment_number,
  output logic                                out_last_of_pixel,
  input  wire logic                           cfg_we,
  input  wire logic [rld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rld_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int LXW  = $clog2(MAX_WIDTH + 1);
  localparam int LYW  = $clog2(MAX_HEIGHT + 1);
  localparam int CMPX = (LXW > rld_pkg::SIZE_W) ? LXW : rld_pkg::SIZE_W;
  localparam int CMPY = (LYW > rld_pkg::SIZE_W) ? LYW : rld_pkg::SIZE_W;
  localparam int SXW  = (LXW + 1 > rld_pkg::COORD_W) ? LXW + 1 : rld_pkg::COORD_W;
  localparam int SYW  = (LYW + 1 > rld_pkg::COORD_W) ? LYW + 1 : rld_pkg::COORD_W;
  localparam int EW   = rld_pkg::EPOCH_W;
  localparam int NW   = rld_pkg::SEG_NUM_W;

  typedef struct packed {
    logic [EW-1:0]  epoch;
    logic [YW-1:0]  start;
    logic [LYW-1:0] len;
  } col_ent_t;

  // ---------------- configuration ----------------
  logic [rld_pkg::SIZE_W-1:0]  image_width_r, image_height_r, min_run_r;
  logic [rld_pkg::LEVEL_W-1:0] dark_level_r;
  logic [NW-1:0]               max_segments_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= rld_pkg::RST_IMAGE_WIDTH;
      image_height_r <= rld_pkg::RST_IMAGE_HEIGHT;
      min_run_r      <= rld_pkg::RST_MIN_RUN;
      dark_level_r   <= rld_pkg::RST_DARK_LEVEL;
      max_segments_r <= rld_pkg::RST_MAX_SEGMENTS;
    end else if (cfg_we) begin
      unique case (rld_pkg::cfg_reg_t'(cfg_index))
        rld_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[rld_pkg::SIZE_W-1:0];
        rld_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[rld_pkg::SIZE_W-1:0];
        rld_pkg::CFG_MIN_RUN:      min_run_r      <= cfg_wdata[rld_pkg::SIZE_W-1:0];
        rld_pkg::CFG_DARK_LEVEL:   dark_level_r   <= cfg_wdata[rld_pkg::LEVEL_W-1:0];
        rld_pkg::CFG_MAX_SEGMENTS: max_segments_r <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- position tracking at acceptance ----------------
  logic [XW-1:0] pos_x_r, pos_x_nxt;
  logic [YW-1:0] pos_y_r, pos_y_nxt;
  logic [EW-1:0] epoch_r, epoch_nxt;
  logic          clr_active_r, clr_active_nxt;
  logic [XW-1:0] clr_addr_r, clr_addr_nxt;

  logic [CMPX-1:0] w_cfg, w_eff;
  logic [CMPY-1:0] h_cfg, h_eff;
  logic            row_end, col_end, in_acc, clr_we;

  always_comb begin
    w_cfg = CMPX'(image_width_r);
    h_cfg = CMPY'(image_height_r);
    if (w_cfg == '0)                   w_eff = CMPX'(1);
    else if (w_cfg > CMPX'(MAX_WIDTH)) w_eff = CMPX'(MAX_WIDTH);
    else                               w_eff = w_cfg;
    if (h_cfg == '0)                    h_eff = CMPY'(1);
    else if (h_cfg > CMPY'(MAX_HEIGHT)) h_eff = CMPY'(MAX_HEIGHT);
    else                                h_eff = h_cfg;
    row_end = (CMPX'(pos_x_r) + CMPX'(1)) >= w_eff;
    col_end = (CMPY'(pos_y_r) + CMPY'(1)) >= h_eff;
  end

  // ---------------- pixel register ----------------
  logic                      s1_valid_r;
  logic [rld_pkg::PIX_W-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic [XW-1:0]             s1_x_r;
  logic [YW-1:0]             s1_y_r;
  logic                      s1_row_end_r, s1_col_end_r;
  logic [EW-1:0]             s1_epoch_r;
  logic                      s1_fire;

  assign in_stall = clr_active_r || (s1_valid_r && !s1_fire);
  assign in_acc   = in_valid && !in_stall;
  assign clr_we   = clr_active_r && !s1_valid_r;

  always_comb begin
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    epoch_nxt      = epoch_r;
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (in_acc) begin
      if (row_end) begin
        pos_x_nxt = '0;
        if (col_end) begin
          pos_y_nxt = '0;
          epoch_nxt = epoch_r + EW'(1);
          if (epoch_r == '1) begin
            clr_active_nxt = 1'b1;
            clr_addr_nxt   = '0;
          end
        end else begin
          pos_y_nxt = pos_y_r + YW'(1);
        end
      end else begin
        pos_x_nxt = pos_x_r + XW'(1);
      end
    end
    if (clr_we) begin
      if (clr_addr_r == XW'(MAX_WIDTH - 1)) clr_active_nxt = 1'b0;
      else                                  clr_addr_nxt   = clr_addr_r + XW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      epoch_r      <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      epoch_r      <= epoch_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_red_r     <= in_red;
      s1_green_r   <= in_green;
      s1_blue_r    <= in_blue;
      s1_x_r       <= pos_x_r;
      s1_y_r       <= pos_y_r;
      s1_row_end_r <= row_end;
      s1_col_end_r <= col_end;
      s1_epoch_r   <= epoch_r;
    end
  end

  // ---------------- column store ----------------
  col_ent_t      col_mem [MAX_WIDTH];
  col_ent_t      col_rd_r;
  logic          mem_we;
  logic [XW-1:0] mem_wa;
  col_ent_t      mem_wd, col_wr;

  // most recent write, forwarded when the pixel in hand read the same column
  logic          lw_valid_r;
  logic [XW-1:0] lw_addr_r;
  col_ent_t      lw_data_r;

  always_comb begin
    mem_we = s1_fire || clr_we;
    if (s1_fire) begin
      mem_wa = s1_x_r;
      mem_wd = col_wr;
    end else begin
      mem_wa = clr_addr_r;
      mem_wd = '{epoch: '0, start: '0, len: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) col_rd_r <= col_mem[pos_x_r];
    if (mem_we) col_mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (mem_we) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lw_addr_r <= mem_wa;
      lw_data_r <= mem_wd;
    end
  end

  // ---------------- run update for the pixel in hand ----------------
  logic [NW-1:0]  seg_r, seg_nxt, seg_after_row;
  logic [XW-1:0]  row_start_r, row_start_nxt;
  logic [LXW-1:0] row_len_r, row_len_nxt, row_len1;
  col_ent_t       col_cur;
  logic [LYW-1:0] col_len0, col_len1;
  logic [YW-1:0]  col_start;
  logic           dark, row_close, col_close, rep_row, rep_col;
  logic [SXW-1:0] row_x_end;
  logic [SYW-1:0] col_y_end;
  rld_pkg::seg_t  row_res, col_res;
  rld_pkg::seg_t  res [2];
  logic [1:0]     n_res;

  always_comb begin
    dark = (s1_red_r < dark_level_r) && (s1_green_r < dark_level_r) &&
           (s1_blue_r < dark_level_r);

    row_start_nxt = (dark && row_len_r == '0) ? s1_x_r : row_start_r;
    row_len1      = dark ? row_len_r + LXW'(1) : row_len_r;
    row_close     = !dark || s1_row_end_r;
    rep_row       = row_close && row_len1 != '0 &&
                    CMPX'(row_len1) >= CMPX'(min_run_r) && seg_r < max_segments_r;
    seg_after_row = seg_r + NW'(rep_row);

    col_cur   = (lw_valid_r && lw_addr_r == s1_x_r) ? lw_data_r : col_rd_r;
    col_len0  = (col_cur.epoch == s1_epoch_r) ? col_cur.len : '0;
    col_start = (dark && col_len0 == '0) ? s1_y_r : col_cur.start;
    col_len1  = dark ? col_len0 + LYW'(1) : col_len0;
    col_close = !dark || s1_col_end_r;
    rep_col   = col_close && col_len1 != '0 &&
                CMPY'(col_len1) >= CMPY'(min_run_r) && seg_after_row < max_segments_r;

    col_wr = '{epoch: s1_epoch_r, start: col_start, len: col_close ? '0 : col_len1};

    row_x_end = SXW'(row_start_nxt) + SXW'(row_len1) - SXW'(1);
    col_y_end = SYW'(col_start) + SYW'(col_len1) - SYW'(1);

    row_res.x_start  = rld_pkg::COORD_W'(row_start_nxt);
    row_res.y_start  = rld_pkg::COORD_W'(s1_y_r);
    row_res.x_end    = row_x_end[rld_pkg::COORD_W-1:0];
    row_res.y_end    = rld_pkg::COORD_W'(s1_y_r);
    row_res.vertical = 1'b0;
    row_res.number   = seg_r;
    row_res.last     = !rep_col;

    col_res.x_start  = rld_pkg::COORD_W'(s1_x_r);
    col_res.y_start  = rld_pkg::COORD_W'(col_start);
    col_res.x_end    = rld_pkg::COORD_W'(s1_x_r);
    col_res.y_end    = col_y_end[rld_pkg::COORD_W-1:0];
    col_res.vertical = 1'b1;
    col_res.number   = seg_after_row;
    col_res.last     = 1'b1;

    res[0] = rep_row ? row_res : col_res;
    res[1] = col_res;
    n_res  = {1'b0, rep_row} + {1'b0, rep_col};

    row_len_nxt = row_close ? '0 : row_len1;
    if (s1_row_end_r && s1_col_end_r) seg_nxt = '0;
    else                              seg_nxt = seg_after_row + NW'(rep_col);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= '0;
      row_start_r <= '0;
      row_len_r   <= '0;
    end else if (s1_fire) begin
      seg_r       <= seg_nxt;
      row_start_r <= row_start_nxt;
      row_len_r   <= row_len_nxt;
    end
  end

  // ---------------- two-entry output buffer, head in slot 0 ----------------
  rld_pkg::seg_t q_r [2];
  rld_pkg::seg_t q_nxt [2];
  rld_pkg::seg_t q_sh [2];
  logic [1:0]    cnt_r, cnt_nxt, kept, space, push_n;
  logic          pop;

  always_comb begin
    pop     = (cnt_r != 2'd0) && !out_stall;
    space   = 2'd2 - cnt_r + {1'b0, pop};
    s1_fire = s1_valid_r && (n_res <= space);
    push_n  = s1_fire ? n_res : 2'd0;
    kept    = cnt_r - {1'b0, pop};
    q_sh[0] = pop ? q_r[1] : q_r[0];
    q_sh[1] = q_r[1];
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < kept) q_nxt[i] = q_sh[i];
      else              q_nxt[i] = res[1'(2'(i) - kept)];
    end
    cnt_nxt = kept + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_valid          = cnt_r != 2'd0;
  assign out_seg_x_start    = q_r[0].x_start;
  assign out_seg_y_start    = q_r[0].y_start;
  assign out_seg_x_end      = q_r[0].x_end;
  assign out_seg_y_end      = q_r[0].y_end;
  assign out_is_vertical    = q_r[0].vertical;
  assign out_segment_number = q_r[0].number;
  assign out_last_of_pixel  = q_r[0].last;

endmodule

`default_nettype wire

// ----- rtl/rld_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "run_length_line_detector_macros.svh"

module rld_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [rld_pkg::COORD_W-1:0]   out_seg_x_start,
  input wire logic [rld_pkg::COORD_W-1:0]   out_seg_y_start,
  input wire logic [rld_pkg::COORD_W-1:0]   out_seg_x_end,
  input wire logic [rld_pkg::COORD_W-1:0]   out_seg_y_end,
  input wire logic                          out_is_vertical,
  input wire logic [rld_pkg::SEG_NUM_W-1:0] out_segment_number,
  input wire logic                          out_last_of_pixel
);

  // a held item keeps its number, x start and y end
  `RLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_segment_number) && $stable(out_seg_x_start) && $stable(out_seg_y_end), "stalled item changed")

  // the second item of a pixel is already buffered and is a column segment
  `RLD_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && !out_stall && !out_last_of_pixel, out_valid && out_is_vertical, "second item of a pixel missing")

  // items of one pixel carry consecutive numbers
  `RLD_ASSERT_NEXT(a_pair_number, clk, rst_n, out_valid && !out_stall && !out_last_of_pixel, out_segment_number == $past(out_segment_number) + 16'd1, "segment numbers not consecutive")

  // column segments stay in one column, row segments in one row
  `RLD_ASSERT_NOW(a_seg_axis, clk, rst_n, out_valid, out_is_vertical ? (out_seg_x_start == out_seg_x_end) : (out_seg_y_start == out_seg_y_end), "segment not axis aligned")

endmodule

bind run_length_line_detector rld_checker u_rld_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_seg_x_start    (out_seg_x_start),
  .out_seg_y_start    (out_seg_y_start),
  .out_seg_x_end      (out_seg_x_end),
  .out_seg_y_end      (out_seg_y_end),
  .out_is_vertical    (out_is_vertical),
  .out_segment_number (out_segment_number),
  .out_last_of_pixel  (out_last_of_pixel)
);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int FRAME_MAX    = 1024;

  typedef struct packed {
    logic [rld_pkg::PIX_W-1:0] r;
    logic [rld_pkg::PIX_W-1:0] g;
    logic [rld_pkg::PIX_W-1:0] b;
  } pixel_t;

  typedef enum {PAT_LINES, PAT_NOISE, PAT_SOLID} pattern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rld_pkg::PIX_W-1:0] in_red = '0;
  logic [rld_pkg::PIX_W-1:0] in_green = '0;
  logic [rld_pkg::PIX_W-1:0] in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rld_pkg::COORD_W-1:0] out_seg_x_start;
  logic [rld_pkg::COORD_W-1:0] out_seg_y_start;
  logic [rld_pkg::COORD_W-1:0] out_seg_x_end;
  logic [rld_pkg::COORD_W-1:0] out_seg_y_end;
  logic out_is_vertical;
  logic [rld_pkg::SEG_NUM_W-1:0] out_segment_number;
  logic out_last_of_pixel;
  logic cfg_we = 1'b0;
  logic [rld_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rld_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  run_length_line_detector uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_seg_x_start    (out_seg_x_start),
    .out_seg_y_start    (out_seg_y_start),
    .out_seg_x_end      (out_seg_x_end),
    .out_seg_y_end      (out_seg_y_end),
    .out_is_vertical    (out_is_vertical),
    .out_segment_number (out_segment_number),
    .out_last_of_pixel  (out_last_of_pixel),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Detector shadow: configuration and scan state
  logic [rld_pkg::SIZE_W-1:0]    img_width   = rld_pkg::RST_IMAGE_WIDTH;
  logic [rld_pkg::SIZE_W-1:0]    img_height  = rld_pkg::RST_IMAGE_HEIGHT;
  logic [rld_pkg::SIZE_W-1:0]    min_len     = rld_pkg::RST_MIN_RUN;
  logic [rld_pkg::LEVEL_W-1:0]   dark_level  = rld_pkg::RST_DARK_LEVEL;
  logic [rld_pkg::SEG_NUM_W-1:0] seg_limit   = rld_pkg::RST_MAX_SEGMENTS;
  logic [rld_pkg::COORD_W-1:0]   det_x = '0;
  logic [rld_pkg::COORD_W-1:0]   det_y = '0;
  logic [rld_pkg::COORD_W-1:0]   row_start = '0;
  logic [rld_pkg::SIZE_W-1:0]    row_len = '0;
  logic [rld_pkg::COORD_W-1:0]   col_start [FRAME_MAX];
  logic [rld_pkg::SIZE_W-1:0]    col_len [FRAME_MAX] = '{default: '0};
  logic [rld_pkg::SEG_NUM_W-1:0] seg_count = '0;

  pixel_t        pixel_queue[$];
  rld_pkg::seg_t segments_due[$];
  int     mismatches = 0;
  int     cycle_count = 0;
  int     tx_wait = 0;
  int     tx_burst = 0;
  int     rx_wait = 0;
  int     rx_burst = 0;
  int     hold_left = 0;
  bit     long_hold_req = 1'b0;
  bit     long_hold_done = 1'b0;

  function automatic int size_limit(int v);
    if (v == 0) return 1;
    return (v > FRAME_MAX) ? FRAME_MAX : v;
  endfunction

  function automatic bit can_report(int len);
    return len > 0 && len >= min_len && seg_count < seg_limit;
  endfunction

  task automatic emit_segment(int xs, int ys, int xe, int ye, bit vert);
    rld_pkg::seg_t s;
    s.x_start  = rld_pkg::COORD_W'(xs);
    s.y_start  = rld_pkg::COORD_W'(ys);
    s.x_end    = rld_pkg::COORD_W'(xe);
    s.y_end    = rld_pkg::COORD_W'(ye);
    s.vertical = vert;
    s.number   = seg_count;
    s.last     = 1'b0;
    segments_due.push_back(s);
    seg_count = seg_count + 1'b1;
  endtask

  task automatic detect_pixel(logic [rld_pkg::PIX_W-1:0] r, logic [rld_pkg::PIX_W-1:0] g,
                              logic [rld_pkg::PIX_W-1:0] b);
    int w, h, x, y, n;
    bit row_end, col_end, dark;
    w = size_limit(img_width);
    h = size_limit(img_height);
    x = det_x;
    y = det_y;
    row_end = x >= w - 1;
    col_end = y >= h - 1;
    dark = r < dark_level && g < dark_level && b < dark_level;
    n = 0;

    if (dark) begin
      if (row_len == 0) row_start = rld_pkg::COORD_W'(x);
      row_len = row_len + 1'b1;
    end
    if (!dark || row_end) begin
      if (can_report(row_len)) begin
        emit_segment(row_start, y, row_start + row_len - 1, y, 1'b0);
        n++;
      end
      row_len = '0;
    end

    if (dark) begin
      if (col_len[x] == 0) col_start[x] = rld_pkg::COORD_W'(y);
      col_len[x] = col_len[x] + 1'b1;
    end
    if (!dark || col_end) begin
      if (can_report(col_len[x])) begin
        emit_segment(x, col_start[x], x, col_start[x] + col_len[x] - 1, 1'b1);
        n++;
      end
      col_len[x] = '0;
    end

    if (n > 0) segments_due[segments_due.size() - 1].last = 1'b1;

    if (row_end) begin
      det_x = '0;
      row_len = '0;
      if (col_end) begin
        det_y = '0;
        seg_count = '0;
        foreach (col_len[i]) col_len[i] = '0;
      end else begin
        det_y = rld_pkg::COORD_W'(y + 1);
      end
    end else begin
      det_x = rld_pkg::COORD_W'(x + 1);
      det_y = rld_pkg::COORD_W'(y);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Pixel driver
  always @(posedge clk) begin : driver
    pixel_t p;
    if (rst_n) begin
      if (in_valid && !in_stall) detect_pixel(in_red, in_green, in_blue);
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          p = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_red   <= p.r;
          in_green <= p.g;
          in_blue  <= p.b;
          if (tx_burst > 0) begin
            tx_burst--;
            tx_wait = 0;
          end else begin
            tx_wait = $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0) tx_burst = $urandom_range(10, 50);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Segment monitor and receiver stall
  always @(posedge clk) begin : monitor
    rld_pkg::seg_t want;
    bit stall_next;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (segments_due.size() == 0) begin
          mismatches++;
          $display("%0t: no segment expected, got (%0d,%0d)-(%0d,%0d) vert %0d num %0d last %0d",
                   $time, out_seg_x_start, out_seg_y_start, out_seg_x_end, out_seg_y_end,
                   out_is_vertical, out_segment_number, out_last_of_pixel);
        end else begin
          want = segments_due.pop_front();
          check_field("seg_x_start", want.x_start, out_seg_x_start);
          check_field("seg_y_start", want.y_start, out_seg_y_start);
          check_field("seg_x_end", want.x_end, out_seg_x_end);
          check_field("seg_y_end", want.y_end, out_seg_y_end);
          check_field("is_vertical", want.vertical, out_is_vertical);
          check_field("segment_number", want.number, out_segment_number);
          check_field("last_of_pixel", want.last, out_last_of_pixel);
        end
        if (rx_burst > 0) begin
          rx_burst--;
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, 7);
          if ($urandom_range(0, 15) == 0) rx_burst = $urandom_range(10, 40);
        end
      end
      // one long hold-off so the output buffer fills and the input backs up
      if (long_hold_req && !long_hold_done) begin
        hold_left = 300;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || in_valid || segments_due.size() != 0);
  endtask

  // Pixels that cause no segment may still be in flight; also sit out any clearing pass.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(rld_pkg::cfg_reg_t idx, int value, int bits);
    logic [rld_pkg::CFG_DATA_W-1:0] data;
    data = rld_pkg::CFG_DATA_W'(value);
    // junk above the register width must be ignored
    if (bits < rld_pkg::CFG_DATA_W && $urandom_range(0, 1) == 1)
      data = data | (rld_pkg::CFG_DATA_W'($urandom) << bits);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      rld_pkg::CFG_IMAGE_WIDTH:  img_width  = data[rld_pkg::SIZE_W-1:0];
      rld_pkg::CFG_IMAGE_HEIGHT: img_height = data[rld_pkg::SIZE_W-1:0];
      rld_pkg::CFG_MIN_RUN:      min_len    = data[rld_pkg::SIZE_W-1:0];
      rld_pkg::CFG_DARK_LEVEL:   dark_level = data[rld_pkg::LEVEL_W-1:0];
      rld_pkg::CFG_MAX_SEGMENTS: seg_limit  = data[rld_pkg::SEG_NUM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int w, int h, int min_run, int level, int limit);
    wait_idle();
    write_reg(rld_pkg::CFG_IMAGE_WIDTH, w, rld_pkg::SIZE_W);
    write_reg(rld_pkg::CFG_IMAGE_HEIGHT, h, rld_pkg::SIZE_W);
    write_reg(rld_pkg::CFG_MIN_RUN, min_run, rld_pkg::SIZE_W);
    write_reg(rld_pkg::CFG_DARK_LEVEL, level, rld_pkg::LEVEL_W);
    write_reg(rld_pkg::CFG_MAX_SEGMENTS, limit, rld_pkg::SEG_NUM_W);
  endtask

  // 'D' is dark and anything else light at a level of 100
  task automatic push_marks(string marks);
    pixel_t dark_set[4]  = '{'{8'd0, 8'd0, 8'd0}, '{8'd99, 8'd99, 8'd99},
                             '{8'd0, 8'd99, 8'd0}, '{8'd99, 8'd0, 8'd99}};
    pixel_t light_set[4] = '{'{8'd255, 8'd255, 8'd255}, '{8'd100, 8'd0, 8'd0},
                             '{8'd0, 8'd100, 8'd0}, '{8'd0, 8'd0, 8'd100}};
    for (int i = 0; i < marks.len(); i++)
      pixel_queue.push_back(marks[i] == "D" ? dark_set[i % 4] : light_set[i % 4]);
  endtask

  function automatic pixel_t make_pixel(bit want_dark, int level);
    pixel_t p;
    int k;
    logic [rld_pkg::PIX_W-1:0] ch [3];
    if (want_dark && level > 0) begin
      for (k = 0; k < 3; k++)
        ch[k] = ($urandom_range(0, 3) == 0) ? rld_pkg::PIX_W'(level - 1)
                                            : rld_pkg::PIX_W'($urandom_range(0, level - 1));
    end else begin
      for (k = 0; k < 3; k++) ch[k] = rld_pkg::PIX_W'($urandom_range(0, 255));
      k = $urandom_range(0, 2);
      ch[k] = ($urandom_range(0, 3) == 0) ? rld_pkg::PIX_W'(level)
                                          : rld_pkg::PIX_W'($urandom_range(level, 255));
    end
    p.r = ch[0];
    p.g = ch[1];
    p.b = ch[2];
    return p;
  endfunction

  // Noise, solid or lines (dark columns, the odd dark row, a little speckle)
  task automatic run_phase(int w_raw, int h_raw, int min_run, int level, int limit,
                           int count, pattern_t pat);
    int w, h, gx, gy;
    bit d, row_line;
    bit col_mask [FRAME_MAX];
    set_config(w_raw, h_raw, min_run, level, limit);
    w = size_limit(w_raw);
    h = size_limit(h_raw);
    gx = det_x;
    gy = det_y;
    foreach (col_mask[i]) col_mask[i] = ($urandom_range(0, 2) == 0);
    row_line = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      case (pat)
        PAT_SOLID: d = 1'b1;
        PAT_NOISE: d = $urandom_range(0, 1);
        default:   d = (col_mask[gx] || row_line) ^ ($urandom_range(0, 15) == 0);
      endcase
      pixel_queue.push_back(make_pixel(d, level));
      if (gx >= w - 1) begin
        gx = 0;
        gy = (gy >= h - 1) ? 0 : gy + 1;
        row_line = ($urandom_range(0, 3) == 0);
      end else begin
        gx++;
      end
    end
  endtask

  initial begin : stimulus
    int w, h, mr, dl, ms, n, phase_no, random_items;
    pattern_t pat;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // 4x4 frame: row and column runs closing at light pixels and at both edges,
    // one pixel closing both, and the segment limit cutting the last one
    set_config(4, 4, 2, 100, 5);
    push_marks("DDNDDNNDDDDDDNDD");
    push_marks("DNNN");
    // zero minimum with nothing dark, then everything below 255 dark
    set_config(4, 4, 0, 0, 65535);
    push_marks("DDNN");
    set_config(4, 4, 0, 255, 65535);
    push_marks("DNDD");

    // one-pixel frames: every pixel ends a frame, enough to wrap the frame tag
    run_phase(1, 1, 1, 128, 65535, 270, PAT_NOISE);
    // oversized width and zero height: a long row that does not reach its edge
    run_phase(2047, 0, 1024, 255, 65535, 60, PAT_SOLID);
    // zero width and oversized height: a tall column left open
    run_phase(0, 2047, 1024, 255, 256, 60, PAT_SOLID);

    phase_no = 0;
    random_items = 0;
    while (random_items < 250) begin
      case ($urandom_range(0, 9))
        0:       w = 1;
        1:       w = $urandom_range(13, 40);
        default: w = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 1;
        1:       h = $urandom_range(11, 30);
        default: h = $urandom_range(2, 10);
      endcase
      case ($urandom_range(0, 9))
        0:       mr = 0;
        1:       mr = w;
        2:       mr = 2047;
        default: mr = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0:       dl = 0;
        1:       dl = 255;
        default: dl = $urandom_range(1, 255);
      endcase
      case ($urandom_range(0, 7))
        0:       ms = $urandom_range(0, 4);
        1:       ms = 65535;
        default: ms = 256;
      endcase
      n = $urandom_range(20, 60);
      pat = ($urandom_range(0, 7) == 0) ? PAT_NOISE : PAT_LINES;
      if (phase_no == 3) begin
        mr = 1;
        ms = 65535;
        dl = $urandom_range(50, 255);
        n = 200;
        pat = PAT_LINES;
      end
      run_phase(w, h, mr, dl, ms, n, pat);
      if (phase_no == 3) long_hold_req = 1'b1;
      random_items += n;
      phase_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (segments_due.size() != 0) begin
      mismatches += segments_due.size();
      $display("%0t: %0d segments expected but not seen, first (%0d,%0d)-(%0d,%0d) num %0d",
               $time, segments_due.size(), segments_due[0].x_start, segments_due[0].y_start,
               segments_due[0].x_end, segments_due[0].y_end, segments_due[0].number);
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rld_pkg.sv
rtl/run_length_line_detector.sv
rtl/rld_checker.sv
test/tb.sv
